[hdl/pdec_pkg.sv]
// pdec_pkg: shared types, constants and helper functions for the profiled drive encoder control
// no dependencies
package pdec_pkg;

    localparam int CNT_W   = 16;
    localparam int TGT_W   = 15;
    localparam int PWR_W   = 7;
    localparam int GAIN_W  = 10;
    localparam int FRAC_W  = 9;
    localparam int PROD_W  = 24;
    localparam int QUOT_W  = 8;
    localparam int MUL_W   = 18;
    localparam int CORR_W  = 29;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;

    localparam logic signed [7:0] POWER_LIMIT = 8'sd127;
    localparam logic signed [7:0] BRAKE_POWER = 8'sd13;

    localparam logic signed [1:0] DIR_FWD = 2'sb01;
    localparam logic signed [1:0] DIR_REV = 2'sb11;

    typedef enum logic [CIDX_W-1:0] {
        REG_DIRECTION = 3'd0,
        REG_TARGET    = 3'd1,
        REG_TIMEOUT   = 3'd2,
        REG_MAX_POWER = 3'd3,
        REG_MIN_POWER = 3'd4,
        REG_DRIFT     = 3'd5,
        REG_ACCEL     = 3'd6,
        REG_DECEL     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] rem;
        logic [PROD_W-1:0] dvs;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

    function automatic logic signed [7:0] sat_pwr(input logic signed [21:0] v);
        logic signed [7:0] r;
        if (v > 22'(POWER_LIMIT)) begin
            r = POWER_LIMIT;
        end else if (v < -22'(POWER_LIMIT)) begin
            r = -POWER_LIMIT;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    // truncate toward zero by 256, apply direction, saturate
    function automatic logic signed [7:0] pwr_out(input logic signed [CORR_W-1:0] v,
                                                  input logic signed [1:0] dir);
        logic signed [CORR_W-1:0] adj;
        logic signed [CORR_W-1:0] shr;
        logic signed [21:0]       q;
        logic signed [21:0]       s;
        adj = v[CORR_W-1] ? v + CORR_W'(255) : v;
        shr = adj >>> 8;
        q   = shr[21:0];
        if (dir == DIR_FWD) begin
            s = q;
        end else if (dir == DIR_REV) begin
            s = -q;
        end else begin
            s = '0;
        end
        return sat_pwr(s);
    endfunction

    function automatic logic signed [7:0] brake_out(input logic signed [1:0] dir);
        logic signed [7:0] r;
        if (dir == DIR_FWD) begin
            r = -BRAKE_POWER;
        end else if (dir == DIR_REV) begin
            r = BRAKE_POWER;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

[hdl/pdec_mul.sv]
// pdec_mul: shared signed multiplier with registered product
// depends on pdec_pkg
module pdec_mul
    import pdec_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_W-1:0]   mul_a,
    input  logic signed [MUL_W-1:0]   mul_b,
    output logic signed [2*MUL_W-1:0] mul_p
);

    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [2*MUL_W-1:0] prod_next;

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign mul_p = prod_reg;

endmodule

[hdl/pdec_div.sv]
// pdec_div: restoring divider, one quotient bit per cycle, for the ramp fraction
// depends on pdec_pkg; expects the starting remainder below the divisor
module pdec_div
    import pdec_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  div_req_t  req,
    output div_stat_t stat
);

    logic [PROD_W-1:0]         rem_reg, rem_next;
    logic [PROD_W-1:0]         dvs_reg, dvs_next;
    logic [QUOT_W-1:0]         quot_reg, quot_next;
    logic [$clog2(QUOT_W)-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [PROD_W:0]           shifted;
    logic [PROD_W:0]           diff;
    logic                      fits;

    always_comb begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = shifted >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem;
            dvs_next  = req.dvs;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(QUOT_W))'(QUOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

[hdl/profiled_drive_encoder_control.sv]
// profiled_drive_encoder_control: top level, sequencer and state of the two-wheel drive controller
// depends on pdec_pkg, pdec_mul, pdec_div

// A start beat (tuser 0) captures the encoder and time baselines, arms the move and
// returns zero power. A sample beat (tuser 1) returns left and right power from a
// trapezoidal profile with drift correction; the stop test uses the previous sample's
// average distance and elapsed time, and once it trips every sample returns brake power
// with the done flag. A drive sample steps through the sequencer states in order; one
// shared 18x18 multiplier is used four times in sequence and, when the ramp fraction is
// needed, the 8-bit restoring divider forms its quotient in 8 steps. Start and brake
// beats go straight from accept to the emit state. The block takes one beat at a time
// and is ready again once the result has moved into the output register; a result
// waits for m_tready while the output register still holds the previous result.
module profiled_drive_encoder_control
    import pdec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // left_count, right_count, time_ms
    input  logic              s_tuser,   // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // left_power, right_power
    output logic              m_tuser,   // done_res
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_AVG   = 10'b0000000010,
        S_MTA   = 10'b0000000100,
        S_MTD   = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_MBASE = 10'b0000100000,
        S_BASE  = 10'b0001000000,
        S_CORR  = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [1:0]  dir_reg;
    logic [TGT_W-1:0]   tgt_reg;
    logic [CNT_W-1:0]   tmo_reg;
    logic [PWR_W-1:0]   maxp_reg, minp_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [FRAC_W-1:0]  accf_reg, decf_reg;

    logic [CNT_W-1:0]         lbase_reg, lbase_next;
    logic [CNT_W-1:0]         rbase_reg, rbase_next;
    logic [CNT_W-1:0]         stamp_reg, stamp_next;
    logic [CNT_W-1:0]         lavg_reg, lavg_next;
    logic [CNT_W-1:0]         lel_reg, lel_next;
    logic                     fin_reg, fin_next;
    logic signed [CNT_W-1:0]  l_reg, l_next;
    logic signed [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]         avg_reg, avg_next;
    logic signed [CNT_W:0]    err_reg, err_next;
    logic [PROD_W-1:0]        ta_reg, ta_next;
    logic [QUOT_W:0]          boost_reg, boost_next;
    logic signed [8:0]        base_reg, base_next;
    logic signed [CORR_W-1:0] vl_reg, vl_next;
    logic signed [CORR_W-1:0] vr_reg, vr_next;
    logic signed [7:0]        resl_reg, resl_next;
    logic signed [7:0]        resr_reg, resr_next;
    logic                     resd_reg, resd_next;
    logic                     mv_reg, mv_next;
    logic [15:0]              mdata_reg, mdata_next;
    logic                     mdone_reg, mdone_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    div_req_t                  dreq;
    div_stat_t                 dstat;

    logic [CNT_W-1:0]          in_l, in_r, in_t;
    logic                      accept;
    logic                      limit_hit;
    logic [CNT_W:0]            abs_l, abs_r;
    logic [CNT_W+1:0]          abs_sum;
    logic [PROD_W-1:0]         avg256;
    logic [PROD_W-1:0]         td;
    logic                      in_accel, in_decel, past_tgt;
    logic [CNT_W-1:0]          rest;
    logic signed [CORR_W-1:0]  corr, b256, prod_c;
    logic signed [2*MUL_W-1:0] prod_sh;

    pdec_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    pdec_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .stat    (dstat)
    );

    assign in_l      = s_tdata[15:0];
    assign in_r      = s_tdata[31:16];
    assign in_t      = s_tdata[47:32];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = mdone_reg;

    assign limit_hit = fin_reg || (lavg_reg >= {1'b0, tgt_reg}) || (lel_reg >= tmo_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg  <= DIR_FWD;
            tgt_reg  <= '0;
            tmo_reg  <= 16'd5000;
            maxp_reg <= 7'd127;
            minp_reg <= '0;
            gain_reg <= '0;
            accf_reg <= '0;
            decf_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIRECTION: begin
                    dir_reg <= cfg_data[1] ? DIR_REV : $signed(cfg_data[1:0]);
                end
                REG_TARGET:    tgt_reg  <= cfg_data[TGT_W-1:0];
                REG_TIMEOUT:   tmo_reg  <= cfg_data[CNT_W-1:0];
                REG_MAX_POWER: maxp_reg <= cfg_data[PWR_W-1:0];
                REG_MIN_POWER: minp_reg <= cfg_data[PWR_W-1:0];
                REG_DRIFT:     gain_reg <= cfg_data[GAIN_W-1:0];
                REG_ACCEL:     accf_reg <= cfg_data[FRAC_W-1:0];
                REG_DECEL:     decf_reg <= cfg_data[FRAC_W-1:0];
            endcase
        end
    end

    // datapath helpers
    always_comb begin
        abs_l    = l_reg[CNT_W-1] ? -{l_reg[CNT_W-1], l_reg} : {1'b0, l_reg};
        abs_r    = r_reg[CNT_W-1] ? -{r_reg[CNT_W-1], r_reg} : {1'b0, r_reg};
        abs_sum  = {1'b0, abs_l} + {1'b0, abs_r};
        avg256   = {avg_reg, 8'd0};
        td       = mul_p[PROD_W-1:0];
        in_accel = avg256 < ta_reg;
        in_decel = ({1'b0, avg256} + {1'b0, td}) > {2'b00, tgt_reg, 8'd0};
        past_tgt = avg_reg >= {1'b0, tgt_reg};
        rest     = {1'b0, tgt_reg} - avg_reg;
        prod_sh  = mul_p >>> 8;
        prod_c   = mul_p[CORR_W-1:0];
        b256     = CORR_W'({base_reg, 8'd0});
        if (dir_reg == DIR_FWD) begin
            corr = prod_c;
        end else if (dir_reg == DIR_REV) begin
            corr = -prod_c;
        end else begin
            corr = '0;
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AVG: begin
                mul_a = MUL_W'(tgt_reg);
                mul_b = MUL_W'(accf_reg);
            end
            S_MTA: begin
                mul_a = MUL_W'(tgt_reg);
                mul_b = MUL_W'(decf_reg);
            end
            S_MBASE: begin
                mul_a = MUL_W'(boost_reg);
                mul_b = $signed(MUL_W'(maxp_reg)) - $signed(MUL_W'(minp_reg));
            end
            S_BASE: begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        lbase_next = lbase_reg;
        rbase_next = rbase_reg;
        stamp_next = stamp_reg;
        lavg_next  = lavg_reg;
        lel_next   = lel_reg;
        fin_next   = fin_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        avg_next   = avg_reg;
        err_next   = err_reg;
        ta_next    = ta_reg;
        boost_next = boost_reg;
        base_next  = base_reg;
        vl_next    = vl_reg;
        vr_next    = vr_reg;
        resl_next  = resl_reg;
        resr_next  = resr_reg;
        resd_next  = resd_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        mdone_next = mdone_reg;
        dreq.start = 1'b0;
        dreq.rem   = in_accel ? avg256 : {rest, 8'd0};
        dreq.dvs   = in_accel ? ta_reg : td;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!s_tuser) begin
                        lbase_next = in_l;
                        rbase_next = in_r;
                        stamp_next = in_t;
                        lavg_next  = '0;
                        lel_next   = '0;
                        fin_next   = 1'b0;
                        resl_next  = '0;
                        resr_next  = '0;
                        resd_next  = 1'b0;
                        state_next = S_EMIT;
                    end else if (limit_hit) begin
                        fin_next   = 1'b1;
                        resl_next  = brake_out(dir_reg);
                        resr_next  = brake_out(dir_reg);
                        resd_next  = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        l_next     = $signed(in_l - lbase_reg);
                        r_next     = $signed(in_r - rbase_reg);
                        lel_next   = in_t - stamp_reg;
                        state_next = S_AVG;
                    end
                end
            end
            S_AVG: begin
                avg_next   = abs_sum[CNT_W:1];
                lavg_next  = abs_sum[CNT_W:1];
                err_next   = {l_reg[CNT_W-1], l_reg} - {r_reg[CNT_W-1], r_reg};
                state_next = S_MTA;
            end
            S_MTA: begin
                ta_next    = mul_p[PROD_W-1:0];
                state_next = S_MTD;
            end
            S_MTD: begin
                if (in_accel) begin
                    dreq.start = 1'b1;
                    state_next = S_DIV;
                end else if (in_decel) begin
                    if (past_tgt || td == '0) begin
                        boost_next = '0;
                        state_next = S_MBASE;
                    end else begin
                        dreq.start = 1'b1;
                        state_next = S_DIV;
                    end
                end else begin
                    boost_next = (QUOT_W+1)'(256);
                    state_next = S_MBASE;
                end
            end
            S_DIV: begin
                if (dstat.done) begin
                    boost_next = {1'b0, dstat.quot};
                    state_next = S_MBASE;
                end
            end
            S_MBASE: begin
                state_next = S_BASE;
            end
            S_BASE: begin
                base_next  = $signed({2'b00, minp_reg}) + prod_sh[8:0];
                state_next = S_CORR;
            end
            S_CORR: begin
                vl_next    = b256 - corr;
                vr_next    = b256 + corr;
                state_next = S_OUT;
            end
            S_OUT: begin
                resl_next  = pwr_out(vl_reg, dir_reg);
                resr_next  = pwr_out(vr_reg, dir_reg);
                resd_next  = 1'b0;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {resr_reg, resl_reg};
                    mdone_next = resd_reg;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lbase_reg <= '0;
            rbase_reg <= '0;
            stamp_reg <= '0;
            lavg_reg  <= '0;
            lel_reg   <= '0;
            fin_reg   <= 1'b1;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            lbase_reg <= lbase_next;
            rbase_reg <= rbase_next;
            stamp_reg <= stamp_next;
            lavg_reg  <= lavg_next;
            lel_reg   <= lel_next;
            fin_reg   <= fin_next;
            mv_reg    <= mv_next;
        end
        l_reg     <= l_next;
        r_reg     <= r_next;
        avg_reg   <= avg_next;
        err_reg   <= err_next;
        ta_reg    <= ta_next;
        boost_reg <= boost_next;
        base_reg  <= base_next;
        vl_reg    <= vl_next;
        vr_reg    <= vr_next;
        resl_reg  <= resl_next;
        resr_reg  <= resr_next;
        resd_reg  <= resd_next;
        mdata_reg <= mdata_next;
        mdone_reg <= mdone_next;
    end

endmodule
